/* rtl/jtbs_pkg.sv */
// Package for the JSON token boundary scanner.
// Holds the scan mode and status codes, character constants and the state struct.
// No dependencies.
package jtbs_pkg;

  localparam int MaxDepth = 32;
  localparam int DepthW   = $clog2(MaxDepth + 1);
  localparam int PtrW     = $clog2(MaxDepth);

  localparam logic [7:0] ChBraceOpen   = 8'h7B;
  localparam logic [7:0] ChSquareOpen  = 8'h5B;
  localparam logic [7:0] ChBraceClose  = 8'h7D;
  localparam logic [7:0] ChSquareClose = 8'h5D;
  localparam logic [7:0] ChComma       = 8'h2C;
  localparam logic [7:0] ChQuote       = 8'h22;

  // Stack entry values.
  localparam logic KindBrace  = 1'b0;
  localparam logic KindSquare = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_BRACKET = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_APPEND       = 3'd0,
    ST_DONE         = 3'd1,
    ST_ENDED_BEFORE = 3'd2,
    ST_UNBALANCED   = 3'd3,
    ST_OVERFLOW     = 3'd4,
    ST_IGNORED      = 3'd5
  } status_t;

  typedef struct packed {
    mode_t             mode;
    logic [DepthW-1:0] depth;
    logic              ever_opened;
  } scan_state_t;

  typedef struct packed {
    logic            en;
    logic [PtrW-1:0] addr;
    logic            kind;
  } push_t;

endpackage

/* rtl/jtbs_step.sv */
// Next-state and status logic for one character of the token scan.
// Reads only the top of the bracket stack. Depends on jtbs_pkg.
module jtbs_step import jtbs_pkg::*; (
  input  logic [7:0]        char_in,
  input  logic              first_of_token,
  input  logic              last_of_input,
  input  scan_state_t       cur,
  input  logic [MaxDepth-1:0] stack,
  output scan_state_t       nxt,
  output status_t           status,
  output push_t             push
);

  logic [DepthW-1:0] base_depth;
  logic              base_ever;
  logic              do_bracket;
  logic              is_open;
  logic              is_close;
  logic              top_kind;
  logic [DepthW-1:0] depth_dec;

  always_comb begin
    base_depth = first_of_token ? '0 : cur.depth;
    base_ever  = first_of_token ? 1'b0 : cur.ever_opened;
    is_open    = (char_in == ChBraceOpen) || (char_in == ChSquareOpen);
    is_close   = (char_in == ChBraceClose) || (char_in == ChSquareClose);
    depth_dec  = base_depth - DepthW'(1);
    top_kind   = stack[depth_dec[PtrW-1:0]];

    nxt.mode        = cur.mode;
    nxt.depth       = base_depth;
    nxt.ever_opened = base_ever;
    status          = ST_APPEND;
    push.en         = 1'b0;
    push.addr       = base_depth[PtrW-1:0];
    push.kind       = (char_in == ChSquareOpen) ? KindSquare : KindBrace;
    do_bracket      = 1'b0;

    if (first_of_token) begin
      if (char_in == ChQuote) begin
        if (last_of_input) begin
          nxt.mode = MODE_IDLE;
          status   = ST_UNBALANCED;
        end else begin
          nxt.mode = MODE_STRING;
        end
      end else begin
        nxt.mode   = MODE_BRACKET;
        do_bracket = 1'b1;
      end
    end else begin
      unique case (cur.mode)
        MODE_STRING: begin
          if (char_in == ChQuote) begin
            nxt.mode = MODE_IDLE;
            status   = ST_DONE;
          end else if (last_of_input) begin
            nxt.mode = MODE_IDLE;
            status   = ST_UNBALANCED;
          end
        end
        MODE_BRACKET: do_bracket = 1'b1;
        default: begin
          nxt.mode = MODE_IDLE;
          status   = ST_IGNORED;
        end
      endcase
    end

    if (do_bracket) begin
      // Errors and early ends win over the end of input.
      if (is_open && (base_depth >= DepthW'(MaxDepth))) begin
        nxt.mode = MODE_IDLE;
        status   = ST_OVERFLOW;
      end else if (is_close && (base_depth == '0)) begin
        nxt.mode = MODE_IDLE;
        status   = base_ever ? ST_UNBALANCED : ST_ENDED_BEFORE;
      end else if (is_close &&
                   (top_kind != ((char_in == ChSquareClose) ? KindSquare : KindBrace))) begin
        nxt.mode = MODE_IDLE;
        status   = ST_UNBALANCED;
      end else if ((char_in == ChComma) && (base_depth == '0)) begin
        nxt.mode = MODE_IDLE;
        status   = ST_ENDED_BEFORE;
      end else begin
        if (is_open) begin
          push.en         = 1'b1;
          nxt.depth       = base_depth + DepthW'(1);
          nxt.ever_opened = 1'b1;
        end else if (is_close) begin
          nxt.depth = depth_dec;
        end
        if (last_of_input) begin
          nxt.mode = MODE_IDLE;
          status   = ST_DONE;
        end
      end
    end
  end

endmodule

/* rtl/json_token_boundary_scanner.sv */
// Top level of the JSON token boundary scanner: input register, scan state,
// bracket stack and result register. Depends on jtbs_pkg and jtbs_step.
//
//   channel | handshake             | payload
//   input   | in_valid / in_ready   | char_in, first_of_token, last_of_input
//   output  | out_valid / out_ready | char_out, status, nesting_depth
//
// One character per cycle while the output is not stalled; the input register feeds
// the step logic into the result register.
// The scan state and the 32-entry bracket stack update as a character moves
// into the result register; the step logic reads only the stack top.
// A stalled output holds the result and the input register, and in_ready drops once the input register is full.
// Synchronous reset clears valids and scan state; stack contents are not cleared.
module json_token_boundary_scanner import jtbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        char_in,
  input  logic              first_of_token,
  input  logic              last_of_input,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        char_out,
  output logic [2:0]        status,
  output logic [DepthW-1:0] nesting_depth
);

  logic                s1_valid;
  logic [7:0]          s1_char;
  logic                s1_first;
  logic                s1_last;
  logic                advance;
  scan_state_t         state;
  scan_state_t         state_next;
  status_t             step_status;
  push_t               push;
  logic [MaxDepth-1:0] stack;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  jtbs_step u_step (
    .char_in        (s1_char),
    .first_of_token (s1_first),
    .last_of_input  (s1_last),
    .cur            (state),
    .stack          (stack),
    .nxt            (state_next),
    .status         (step_status),
    .push           (push)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char  <= char_in;
      s1_first <= first_of_token;
      s1_last  <= last_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode        <= MODE_IDLE;
      state.depth       <= '0;
      state.ever_opened <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && push.en) begin
      stack[push.addr] <= push.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      char_out      <= s1_char;
      status        <= step_status;
      nesting_depth <= state_next.depth;
    end
  end

endmodule

/* rtl/jtbs_checker.sv */
// Port-level checker for the JSON token boundary scanner, bound to the top level.
// Depends on jtbs_pkg and json_token_boundary_scanner.
module jtbs_checker import jtbs_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [7:0]        char_out,
  input logic [2:0]        status,
  input logic [DepthW-1:0] nesting_depth
);

  // A reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_IGNORED))
    else $error("status code out of range");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (nesting_depth <= DepthW'(MaxDepth)))
    else $error("nesting depth beyond the stack size");

  // A stalled result holds its payload until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(status)
      && $stable(nesting_depth))
    else $error("stalled result changed");

  // An input transfer is followed by a valid result.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("no result after an input transfer");

endmodule

bind json_token_boundary_scanner jtbs_checker u_jtbs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .char_out      (char_out),
  .status        (status),
  .nesting_depth (nesting_depth)
);

/* dv/json_token_boundary_scanner_tb.sv */
// Self-checking testbench for json_token_boundary_scanner.
// Tracks scan mode, depth and bracket kinds in its own copy and checks every
// echoed character, status and depth. Depends on jtbs_pkg and the scanner RTL.
module json_token_boundary_scanner_tb;
  import jtbs_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned TailItems = 90;

  typedef struct packed {
    logic [7:0]        ch;
    status_t           st;
    logic [DepthW-1:0] depth;
  } char_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        char_in = '0;
  logic              first_of_token = 1'b0;
  logic              last_of_input = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        char_out;
  logic [2:0]        status;
  logic [DepthW-1:0] nesting_depth;

  // Scanner state as this bench sees it.
  mode_t             track_mode = MODE_IDLE;
  logic [DepthW-1:0] track_depth = '0;
  logic              track_kinds [MaxDepth];
  logic              track_opened = 1'b0;

  char_result_t awaited_results [$];
  int unsigned  fail_cnt = 0;
  int unsigned  sent_cnt = 0;
  int unsigned  status_cnt [6];
  int unsigned  gap_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  stall_left = 0;
  int unsigned  quiet_cycles = 0;

  json_token_boundary_scanner i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_in        (char_in),
    .first_of_token (first_of_token),
    .last_of_input  (last_of_input),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .char_out       (char_out),
    .status         (status),
    .nesting_depth  (nesting_depth)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit is_opener(logic [7:0] c);
    return c == ChBraceOpen || c == ChSquareOpen;
  endfunction

  function automatic bit is_closer(logic [7:0] c);
    return c == ChBraceClose || c == ChSquareClose;
  endfunction

  // One character of a bracket scan; updates the tracked stack.
  function automatic status_t bracket_status(logic [7:0] c, logic last);
    logic kind;
    kind = (c == ChSquareOpen || c == ChSquareClose) ? KindSquare : KindBrace;
    if (is_opener(c)) begin
      if (track_depth >= MaxDepth) begin
        track_mode = MODE_IDLE;
        return ST_OVERFLOW;
      end
      track_kinds[track_depth] = kind;
      track_depth = track_depth + 1'b1;
      track_opened = 1'b1;
    end else if (is_closer(c)) begin
      if (track_depth == 0) begin
        track_mode = MODE_IDLE;
        return track_opened ? ST_UNBALANCED : ST_ENDED_BEFORE;
      end
      if (track_kinds[track_depth - 1'b1] != kind) begin
        track_mode = MODE_IDLE;
        return ST_UNBALANCED;
      end
      track_depth = track_depth - 1'b1;
    end else if (c == ChComma && track_depth == 0) begin
      track_mode = MODE_IDLE;
      return ST_ENDED_BEFORE;
    end
    if (last) begin
      track_mode = MODE_IDLE;
      return ST_DONE;
    end
    return ST_APPEND;
  endfunction

  function automatic char_result_t scan_result(logic [7:0] c, logic first, logic last);
    char_result_t r;
    status_t      st;
    if (first) begin
      track_depth = '0;
      track_opened = 1'b0;
      if (c == ChQuote) begin
        track_mode = last ? MODE_IDLE : MODE_STRING;
        st = last ? ST_UNBALANCED : ST_APPEND;
      end else begin
        track_mode = MODE_BRACKET;
        st = bracket_status(c, last);
      end
    end else if (track_mode == MODE_STRING) begin
      if (c == ChQuote) begin
        track_mode = MODE_IDLE;
        st = ST_DONE;
      end else if (last) begin
        track_mode = MODE_IDLE;
        st = ST_UNBALANCED;
      end else begin
        st = ST_APPEND;
      end
    end else if (track_mode == MODE_BRACKET) begin
      st = bracket_status(c, last);
    end else begin
      st = ST_IGNORED;
    end
    r.ch = c;
    r.st = st;
    r.depth = track_depth;
    return r;
  endfunction

  // Plain text byte: never a quote inside a string; never a bracket, and no
  // comma at the top level, inside a bracket scan.
  function automatic logic [7:0] text_char(bit in_string, bit at_top);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (in_string ? (c == ChQuote)
                         : (is_opener(c) || is_closer(c) || (at_top && c == ChComma)));
    return c;
  endfunction

  task automatic send_char(logic [7:0] c, logic first, logic last);
    char_result_t r;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in <= c;
    first_of_token <= first;
    last_of_input <= last;
    do @(posedge clk); while (!in_ready);
    r = scan_result(c, first, last);
    awaited_results.push_back(r);
    status_cnt[r.st]++;
    sent_cnt++;
  endtask

  task automatic send_text(string s, logic first, logic last);
    int n;
    n = s.len();
    for (int i = 0; i < n; i++) begin
      send_char(s[i], first && i == 0, last && i == n - 1);
    end
  endtask

  // Lower valid and hold off until the scanner has drained.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_quoted_token();
    int unsigned len;
    len = $urandom_range(0, 8);
    send_char(ChQuote, 1'b1, 1'b0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        send_char(text_char(1'b1, 1'b0), 1'b0, 1'b1);
        return;
      end
      send_char(text_char(1'b1, 1'b0), 1'b0, 1'b0);
    end
    send_char(ChQuote, 1'b0, $urandom_range(0, 9) == 0);
  endtask

  // Bracketed token: dives to a starting depth, walks at random, then closes.
  task automatic send_nested_token(int unsigned dive, int unsigned steps, int unsigned cap);
    logic       kinds [$];
    logic       k;
    logic [7:0] c;
    int unsigned roll;
    for (int unsigned i = 0; i < dive; i++) begin
      k = logic'($urandom_range(0, 1));
      kinds.push_back(k);
      send_char(k ? ChSquareOpen : ChBraceOpen, i == 0, 1'b0);
      if (kinds.size() > MaxDepth) return;
    end
    for (int unsigned i = 0; i < steps; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_char(text_char(1'b0, kinds.size() == 0), 1'b0, 1'b1);
        return;
      end else if (roll < 6 && kinds.size() != 0) begin
        // Wrong closer for the innermost bracket.
        send_char(kinds[$] ? ChBraceClose : ChSquareClose, 1'b0, 1'b0);
        return;
      end else if (roll < 35 && kinds.size() < cap) begin
        k = logic'($urandom_range(0, 1));
        kinds.push_back(k);
        send_char(k ? ChSquareOpen : ChBraceOpen, 1'b0, 1'b0);
        if (kinds.size() > MaxDepth) return;
      end else if (roll < 60 && kinds.size() != 0) begin
        k = kinds.pop_back();
        send_char(k ? ChSquareClose : ChBraceClose, 1'b0, 1'b0);
      end else begin
        send_char(text_char(1'b0, kinds.size() == 0), 1'b0, 1'b0);
      end
    end
    while (kinds.size() != 0) begin
      k = kinds.pop_back();
      send_char(k ? ChSquareClose : ChBraceClose, 1'b0, 1'b0);
    end
    roll = $urandom_range(0, 9);
    if (roll < 5) begin
      send_char(ChComma, 1'b0, 1'b0);
    end else if (roll < 7) begin
      c = roll[0] ? ChBraceClose : ChSquareClose;
      send_char(c, 1'b0, 1'b0);
    end else if (roll == 7) begin
      send_char(text_char(1'b0, 1'b1), 1'b0, 1'b1);
    end
  endtask

  task automatic send_scalar_token();
    int unsigned len;
    len = $urandom_range(1, 6);
    for (int unsigned i = 0; i < len; i++) begin
      send_char(text_char(1'b0, 1'b1), i == 0, 1'b0);
    end
    send_char($urandom_range(0, 1) ? ChComma : ChBraceClose, 1'b0, $urandom_range(0, 3) == 0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic send_random_token();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      send_quoted_token();
    end else if (pick < 70) begin
      send_nested_token($urandom_range(1, 3), $urandom_range(1, 16), 6);
    end else if (pick < 73) begin
      send_nested_token($urandom_range(MaxDepth - 4, MaxDepth), $urandom_range(4, 20),
                        MaxDepth + 1);
    end else if (pick < 86) begin
      send_scalar_token();
    end else begin
      send_noise();
    end
  endtask

  task automatic test_directed();
    // Characters before any token start are ignored.
    send_char(8'h00, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b1);
    send_text("\"a\"", 1'b1, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0);
    // A lone opening quote at the end of input, and a string cut off.
    send_char(ChQuote, 1'b1, 1'b1);
    send_text("\"x", 1'b1, 1'b1);
    send_char(ChQuote, 1'b1, 1'b0);
    send_char(8'h00, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(ChQuote, 1'b0, 1'b0);
    send_text("{[]},", 1'b1, 1'b0);
    send_text("7}", 1'b1, 1'b0);
    send_text("{}]", 1'b1, 1'b0);
    send_text("{]", 1'b1, 1'b0);
    // Open brackets at the end of input are fine; the depth is kept afterwards.
    send_text("[{", 1'b1, 1'b1);
    send_char("a", 1'b0, 1'b0);
    send_text("[[", 1'b1, 1'b0);
    send_char("5", 1'b1, 1'b1);
    send_text(",", 1'b1, 1'b0);
    send_text("}", 1'b1, 1'b1);
  endtask

  task automatic test_depth_limit();
    logic kinds [MaxDepth];
    for (int i = 0; i < MaxDepth; i++) begin
      send_char($urandom_range(0, 1) ? ChSquareOpen : ChBraceOpen, i == 0, 1'b0);
    end
    send_char(ChBraceOpen, 1'b0, 1'b0);
    send_char("z", 1'b0, 1'b0);
    for (int i = 0; i < MaxDepth; i++) begin
      kinds[i] = logic'($urandom_range(0, 1));
      send_char(kinds[i] ? ChSquareOpen : ChBraceOpen, i == 0, 1'b0);
    end
    for (int i = MaxDepth - 1; i >= 0; i--) begin
      send_char(kinds[i] ? ChSquareClose : ChBraceClose, 1'b0, i == 0);
    end
  endtask

  task automatic test_drain_pause();
    send_nested_token(2, 8, 4);
    wait_drained();
    send_quoted_token();
    send_text("[1,2]", 1'b1, 1'b1);
  endtask

  task automatic test_random_stream();
    int unsigned stop_at;
    stop_at = sent_cnt + RandomItems;
    while (sent_cnt < stop_at) begin
      // Some stretches run without any idling.
      if ($urandom_range(0, 3) == 0) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = $urandom_range(5, 40);
        stall_pct = $urandom_range(5, 40);
      end
      send_random_token();
    end
  endtask

  task automatic test_full_rate_tail();
    int unsigned stop_at;
    gap_pct = 0;
    stall_pct = 0;
    stop_at = sent_cnt + TailItems;
    while (sent_cnt < stop_at) send_random_token();
  endtask

  // Receiver stalls in bursts.
  always @(posedge clk) begin
    if (stall_pct == 0) begin
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 19);
    end
    out_ready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    char_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing pending: char_out %0h status %0d",
               char_out, status);
        fail_cnt++;
      end else begin
        want = awaited_results.pop_front();
        if (char_out !== want.ch) begin
          $error("char_out: expected %0h, actual %0h", want.ch, char_out);
          fail_cnt++;
        end
        if (status !== want.st) begin
          $error("status: expected %0d, actual %0d", want.st, status);
          fail_cnt++;
        end
        if (nesting_depth !== want.depth) begin
          $error("nesting_depth: expected %0d, actual %0d", want.depth, nesting_depth);
          fail_cnt++;
        end
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_depth_limit();
    test_drain_pause();
    test_random_stream();
    test_full_rate_tail();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Scanned %0d characters of quoted, bracketed, scalar and noise tokens.",
             sent_cnt);
    $display("Status mix: append %0d, done %0d, ended before %0d, unbalanced %0d, %s %0d, %s %0d",
             status_cnt[ST_APPEND], status_cnt[ST_DONE], status_cnt[ST_ENDED_BEFORE],
             status_cnt[ST_UNBALANCED], "overflow", status_cnt[ST_OVERFLOW],
             "ignored", status_cnt[ST_IGNORED]);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
